>>> hw/rtl/fblr_pkg.sv
// Shared types, constants and the CRC step function of the framed byte link receiver.
`default_nettype none
package fblr_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int CRC_SPAN    = 22;

  localparam logic [7:0]  SYNC_FIRST   = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND  = 8'h5A;
  localparam logic [7:0]  LINK_VERSION = 8'h01;
  localparam logic [7:0]  LINK_TYPE    = 8'h01;
  localparam logic [7:0]  FLAG_NIBBLE  = 8'h0F;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  CONF_MAX     = 8'd100;
  localparam logic [15:0] NONE_VALUE   = 16'h8000;

  localparam logic [1:0] REG_POSITION_LIMIT = 2'd0;
  localparam logic [1:0] REG_VELOCITY_LIMIT = 2'd1;
  localparam logic [1:0] REG_MEASURED_MASK  = 2'd2;
  localparam logic [1:0] REG_PREDICTED_MASK = 2'd3;

  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_NEW_SESSION = 3'd1,
    EV_BOOT_CHANGED = 3'd2,
    EV_HEADER = 3'd3,
    EV_CRC = 3'd4,
    EV_SEMANTIC = 3'd5,
    EV_DUPLICATE = 3'd6,
    EV_BACKWARD = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_CRC,
    ST_DECIDE,
    ST_SHIFT
  } eng_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sync_first;
    logic       sync_second;
  } rx_item_t;

  typedef struct packed {
    logic [14:0] position_limit;
    logic [14:0] velocity_limit;
    logic [3:0]  measured_mask;
    logic [3:0]  predicted_mask;
  } cfg_t;

  typedef struct packed {
    event_t      event_code;
    logic [3:0]  frame_flags;
    logic [15:0] sequence_number;
    logic [31:0] capture_time;
    logic [15:0] position_value;
    logic [15:0] velocity_value;
    logic [6:0]  confidence_level;
    logic [7:0]  lost_count;
    logic [7:0]  processing_time;
    logic [15:0] boot_identifier;
    logic [14:0] skipped_sequences;
  } result_t;

  // One byte of CRC-16, MSB first, no reflection.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fblr_queue.sv
// Small first-in first-out queue of fixed-width entries.
`default_nettype none
module fblr_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_wr, do_rd;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fblr_front.sv
// Front end: takes received bytes and tags sync bytes for the frame engine.
`default_nettype none
module fblr_front
  import fblr_pkg::*;
(
  input  wire logic       push,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            full,
  output logic            q_wr,
  output rx_item_t        q_item
);
  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_item.data        = rx_byte;
    q_item.sync_first  = (rx_byte == SYNC_FIRST);
    q_item.sync_second = (rx_byte == SYNC_SECOND);
  end

endmodule
`default_nettype wire

>>> hw/rtl/fblr_engine.sv
// Frame engine: stores frames, runs the CRC, checks payload and session, resynchronizes.
`default_nettype none
module fblr_engine
  import fblr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     q_empty,
  input  wire rx_item_t q_item,
  output logic          q_pop,
  output result_t       res,
  output logic          res_valid,
  input  wire logic     res_pop
);
  localparam logic [4:0] FILL_FULL = 5'(FRAME_BYTES);
  localparam logic [4:0] FILL_LAST = 5'(FRAME_BYTES - 1);
  localparam logic [4:0] CRC_LAST  = 5'(CRC_SPAN - 1);

  logic [7:0] store [FRAME_BYTES];
  eng_state_t state, state_next;
  logic [4:0] fill, fill_next;
  logic [4:0] idx, idx_next;
  logic [15:0] crc, crc_next;
  logic session_open, current_boot_we;
  logic [15:0] current_boot, previous_sequence;
  logic prev_seq_we;
  logic store_we, shift;
  logic res_load;
  result_t res_next;
  logic slot_free;

  logic header_ok, crc_ok, payload_ok, meas, pred;
  logic [7:0] flags;
  logic [15:0] seq, boot, delta, pos_raw, vel_raw;
  logic signed [16:0] pos, vel, pl, vl;
  logic [4:0] shift_left;

  assign slot_free = !res_valid || res_pop;
  assign flags   = store[5];
  assign seq     = {store[7], store[6]};
  assign boot    = {store[21], store[20]};
  assign pos_raw = {store[13], store[12]};
  assign vel_raw = {store[15], store[14]};
  assign pos = {pos_raw[15], pos_raw};
  assign vel = {vel_raw[15], vel_raw};
  assign pl  = {2'b00, cfg.position_limit};
  assign vl  = {2'b00, cfg.velocity_limit};
  assign delta = seq - previous_sequence;
  assign shift_left = fill - 1'b1;

  assign header_ok = (store[0] == SYNC_FIRST) && (store[1] == SYNC_SECOND) &&
                     (store[2] == LINK_VERSION) && (store[3] == LINK_TYPE) &&
                     (store[4] == 8'(FRAME_BYTES));
  assign crc_ok = ({store[23], store[22]} == crc);
  assign meas = |(flags[3:0] & cfg.measured_mask);
  assign pred = |(flags[3:0] & cfg.predicted_mask);

  always_comb begin
    payload_ok = 1'b1;
    if (((flags & ~FLAG_NIBBLE) != 8'h00) || (meas && pred) ||
        (store[16] > CONF_MAX) || (store[19] != 8'h00)) begin
      payload_ok = 1'b0;
    end else if (meas || pred) begin
      if ((pos_raw == NONE_VALUE) || (vel_raw == NONE_VALUE) || (pos < -pl) ||
          (pos > pl) || (vel < -vl) || (vel > vl)) begin
        payload_ok = 1'b0;
      end
    end else if ((pos_raw != NONE_VALUE) || (vel_raw != NONE_VALUE)) begin
      payload_ok = 1'b0;
    end
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    idx_next        = idx;
    crc_next        = crc;
    q_pop           = 1'b0;
    store_we        = 1'b0;
    shift           = 1'b0;
    res_load        = 1'b0;
    res_next        = '0;
    current_boot_we = 1'b0;
    prev_seq_we     = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          priority if (fill == 5'd0) begin
            if (q_item.sync_first) begin
              store_we  = 1'b1;
              fill_next = 5'd1;
            end
          end else if (fill == 5'd1) begin
            if (q_item.sync_second) begin
              store_we  = 1'b1;
              fill_next = 5'd2;
            end else if (!q_item.sync_first) begin
              fill_next = 5'd0;
            end
          end else begin
            store_we  = 1'b1;
            fill_next = fill + 1'b1;
            if (fill == FILL_LAST) begin
              state_next = ST_CRC;
              idx_next   = '0;
              crc_next   = CRC_INIT;
            end
          end
        end
      end
      ST_CRC: begin
        crc_next = crc_byte(crc, store[idx]);
        idx_next = idx + 1'b1;
        if (idx == CRC_LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          res_load = 1'b1;
          if (!header_ok || !crc_ok) begin
            res_next.event_code = header_ok ? EV_CRC : EV_HEADER;
            fill_next  = FILL_FULL;
            state_next = ST_SHIFT;
          end else begin
            fill_next  = '0;
            state_next = ST_COLLECT;
            res_next.frame_flags      = flags[3:0];
            res_next.sequence_number  = seq;
            res_next.capture_time     = {store[11], store[10], store[9], store[8]};
            res_next.position_value   = pos_raw;
            res_next.velocity_value   = vel_raw;
            res_next.confidence_level = store[16][6:0];
            res_next.lost_count       = store[17];
            res_next.processing_time  = store[18];
            res_next.boot_identifier  = boot;
            if (!payload_ok) begin
              res_next.event_code = EV_SEMANTIC;
            end else if (!session_open || (boot != current_boot)) begin
              res_next.event_code = session_open ? EV_BOOT_CHANGED : EV_NEW_SESSION;
              current_boot_we = 1'b1;
              prev_seq_we     = 1'b1;
            end else if (delta == 16'h0000) begin
              res_next.event_code = EV_DUPLICATE;
            end else if (delta[15]) begin
              res_next.event_code = EV_BACKWARD;
            end else begin
              res_next.event_code        = EV_ACCEPTED;
              res_next.skipped_sequences = 15'(delta - 16'd1);
              prev_seq_we = 1'b1;
            end
          end
        end
      end
      ST_SHIFT: begin
        // Drop the oldest byte; stop on a sync pair or on a single trailing byte.
        shift     = 1'b1;
        fill_next = shift_left;
        if (shift_left == 5'd1) begin
          fill_next  = (store[1] == SYNC_FIRST) ? 5'd1 : 5'd0;
          state_next = ST_COLLECT;
        end else if ((store[1] == SYNC_FIRST) && (store[2] == SYNC_SECOND)) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        store[i] <= store[i + 1];
      end
    end else if (store_we) begin
      store[fill] <= q_item.data;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    crc <= crc_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_COLLECT;
      fill              <= '0;
      session_open      <= 1'b0;
      current_boot      <= '0;
      previous_sequence <= '0;
      res_valid         <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (current_boot_we) begin
        session_open <= 1'b1;
        current_boot <= boot;
      end
      if (prev_seq_we) begin
        previous_sequence <= seq;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL) else $error("fill count beyond frame size");
  a_collect_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLLECT) |-> (fill != FILL_FULL)) else $error("full frame left in collect");
  a_crc_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC) |-> (idx <= CRC_LAST)) else $error("crc index out of span");
  a_decide_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) && slot_free |=> res_valid) else $error("frame gave no result");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/framed_byte_link_receiver.sv
// Top level of the framed byte link receiver: configuration registers and block wiring.
`default_nettype none
// Received bytes are taken one per cycle, while the queue is not full, into a byte queue of
// QUEUE_DEPTH entries and consumed by the frame engine at one byte per cycle while it
// collects. A completed 24-byte frame goes through a byte-wise CRC over its first 22 bytes,
// a decision on the result and, after a header or CRC failure, one-byte resync shifts.
// Each completed frame yields one result, held in an output register until popped; the
// engine collects the next frame while a result waits but decides it only once that is popped.
module framed_byte_link_receiver
  import fblr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       event_code,
  output logic [3:0]       frame_flags,
  output logic [15:0]      sequence_number,
  output logic [31:0]      capture_time,
  output logic signed [15:0] position_value,
  output logic signed [15:0] velocity_value,
  output logic [6:0]       confidence_level,
  output logic [7:0]       lost_count,
  output logic [7:0]       processing_time,
  output logic [15:0]      boot_identifier,
  output logic [14:0]      skipped_sequences,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  cfg_t cfg;
  rx_item_t q_item, q_head;
  logic q_wr, q_full, q_empty, q_pop;
  result_t res;
  logic res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_limit <= 15'd1300;
      cfg.velocity_limit <= 15'd5000;
      cfg.measured_mask  <= 4'd1;
      cfg.predicted_mask <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POSITION_LIMIT: cfg.position_limit <= cfg_data;
        REG_VELOCITY_LIMIT: cfg.velocity_limit <= cfg_data;
        REG_MEASURED_MASK:  cfg.measured_mask  <= cfg_data[3:0];
        REG_PREDICTED_MASK: cfg.predicted_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  fblr_front u_front (
    .push    (push),
    .rx_byte (rx_byte),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_item  (q_item)
  );

  fblr_queue #(
    .WIDTH ($bits(rx_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  fblr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty             = !res_valid;
  assign event_code        = res.event_code;
  assign frame_flags       = res.frame_flags;
  assign sequence_number   = res.sequence_number;
  assign capture_time      = res.capture_time;
  assign position_value    = res.position_value;
  assign velocity_value    = res.velocity_value;
  assign confidence_level  = res.confidence_level;
  assign lost_count        = res.lost_count;
  assign processing_time   = res.processing_time;
  assign boot_identifier   = res.boot_identifier;
  assign skipped_sequences = res.skipped_sequences;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the framed byte link receiver: frame stimulus, predictor and checks.
`timescale 1ns / 100ps
module testbench;
  import fblr_pkg::*;

  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [7:0] rx_byte;
  logic empty;
  logic pop;
  logic [2:0] event_code;
  logic [3:0] frame_flags;
  logic [15:0] sequence_number;
  logic [31:0] capture_time;
  logic signed [15:0] position_value;
  logic signed [15:0] velocity_value;
  logic [6:0] confidence_level;
  logic [7:0] lost_count;
  logic [7:0] processing_time;
  logic [15:0] boot_identifier;
  logic [14:0] skipped_sequences;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  framed_byte_link_receiver dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .event_code(event_code), .frame_flags(frame_flags),
    .sequence_number(sequence_number), .capture_time(capture_time),
    .position_value(position_value), .velocity_value(velocity_value),
    .confidence_level(confidence_level), .lost_count(lost_count),
    .processing_time(processing_time), .boot_identifier(boot_identifier),
    .skipped_sequences(skipped_sequences), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Register copies shared by the predictor and the frame generator.
  int pos_limit;
  int vel_limit;
  logic [3:0] meas_mask;
  logic [3:0] pred_mask;

  // Predictor state.
  logic [7:0] frame_buf [FRAME_BYTES];
  int buf_fill;
  logic link_open;
  logic [15:0] link_boot;
  logic [15:0] last_seq;

  logic [7:0] byte_queue [$];
  result_t frame_results [$];

  int idle_mode;
  int hold_requests;
  int hold_served;
  int hold_cnt;
  int quiet_cycles;
  int error_count;
  logic [15:0] gen_seq;
  logic [15:0] gen_boot;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] crc16_frame(input logic [7:0] fr [FRAME_BYTES]);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < CRC_SPAN; i++) begin
      c = c ^ {fr[i], 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Keep the stored bytes from the first sync pair after position zero, else a trailing first sync byte.
  function automatic void realign_buffer();
    int from;
    from = FRAME_BYTES;
    for (int i = 1; i < FRAME_BYTES - 1; i++)
      if (from == FRAME_BYTES && frame_buf[i] == SYNC_FIRST && frame_buf[i + 1] == SYNC_SECOND)
        from = i;
    if (from == FRAME_BYTES && frame_buf[FRAME_BYTES - 1] == SYNC_FIRST) from = FRAME_BYTES - 1;
    for (int k = 0; k < FRAME_BYTES - from; k++) frame_buf[k] = frame_buf[k + from];
    buf_fill = FRAME_BYTES - from;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    result_t res;
    logic [7:0] flags;
    logic [3:0] meas;
    logic [3:0] pred;
    int pos;
    int vel;
    logic ok;
    logic [15:0] seq;
    logic [15:0] boot;
    logic [15:0] delta;
    res = '0;
    if (buf_fill == 0) begin
      if (b == SYNC_FIRST) begin
        frame_buf[0] = b;
        buf_fill = 1;
      end
      return;
    end
    if (buf_fill == 1) begin
      if (b == SYNC_SECOND) begin
        frame_buf[1] = b;
        buf_fill = 2;
      end else if (b != SYNC_FIRST) begin
        buf_fill = 0;
      end
      return;
    end
    frame_buf[buf_fill] = b;
    buf_fill++;
    if (buf_fill != FRAME_BYTES) return;
    if (frame_buf[0] != SYNC_FIRST || frame_buf[1] != SYNC_SECOND ||
        frame_buf[2] != LINK_VERSION || frame_buf[3] != LINK_TYPE ||
        frame_buf[4] != 8'(FRAME_BYTES)) begin
      res.event_code = EV_HEADER;
      realign_buffer();
      frame_results.push_back(res);
      return;
    end
    if ({frame_buf[23], frame_buf[22]} != crc16_frame(frame_buf)) begin
      res.event_code = EV_CRC;
      realign_buffer();
      frame_results.push_back(res);
      return;
    end
    buf_fill = 0;
    seq = {frame_buf[7], frame_buf[6]};
    boot = {frame_buf[21], frame_buf[20]};
    pos = int'($signed({frame_buf[13], frame_buf[12]}));
    vel = int'($signed({frame_buf[15], frame_buf[14]}));
    flags = frame_buf[5];
    meas = flags[3:0] & meas_mask;
    pred = flags[3:0] & pred_mask;
    ok = flags[7:4] == 4'h0 && !(meas != 0 && pred != 0) && frame_buf[16] <= CONF_MAX &&
         frame_buf[19] == 8'h00;
    if ((meas | pred) != 0)
      ok = ok && pos != -32768 && vel != -32768 && pos >= -pos_limit && pos <= pos_limit &&
           vel >= -vel_limit && vel <= vel_limit;
    else
      ok = ok && pos == -32768 && vel == -32768;
    if (!ok) begin
      res.event_code = EV_SEMANTIC;
    end else if (!link_open || boot != link_boot) begin
      res.event_code = link_open ? EV_BOOT_CHANGED : EV_NEW_SESSION;
      link_open = 1'b1;
      link_boot = boot;
      last_seq = seq;
    end else begin
      delta = seq - last_seq;
      if (delta == 16'h0000) begin
        res.event_code = EV_DUPLICATE;
      end else if (delta[15]) begin
        res.event_code = EV_BACKWARD;
      end else begin
        res.event_code = EV_ACCEPTED;
        res.skipped_sequences = 15'(delta - 16'd1);
        last_seq = seq;
      end
    end
    res.frame_flags = flags[3:0];
    res.sequence_number = seq;
    res.capture_time = {frame_buf[11], frame_buf[10], frame_buf[9], frame_buf[8]};
    res.position_value = {frame_buf[13], frame_buf[12]};
    res.velocity_value = {frame_buf[15], frame_buf[14]};
    res.confidence_level = frame_buf[16][6:0];
    res.lost_count = frame_buf[17];
    res.processing_time = frame_buf[18];
    res.boot_identifier = boot;
    frame_results.push_back(res);
  endfunction

  function automatic logic [15:0] pick_value(input int lim, input logic valued);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (!valued && r < 8) return 16'h8000;
    case (r)
      0, 1, 2, 3: v = $urandom_range(0, 2 * lim) - lim;
      4: v = lim;
      5: v = -lim;
      6: v = ($urandom_range(0, 1) != 0) ? lim + 1 : -lim - 1;
      7: return 16'h8000;
      default: return 16'($urandom);
    endcase
    return 16'(v);
  endfunction

  // Queues one frame; fault 0 is well formed, 1 a broken header, 2 a broken CRC.
  task automatic queue_frame(input int fault);
    logic [7:0] fr [FRAME_BYTES];
    logic [15:0] seq;
    logic [15:0] crc;
    logic [7:0] flags;
    logic valued;
    int r;
    int at;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: flags = {4'h0, meas_mask};
      4, 5: flags = {4'h0, pred_mask};
      6: flags = 8'h00;
      7: flags = {4'h0, meas_mask | pred_mask};
      8: flags = {4'h0, 4'($urandom)};
      default: flags = 8'($urandom);
    endcase
    valued = (flags[3:0] & (meas_mask | pred_mask)) != 0;
    r = $urandom_range(0, 19);
    if (r < 14) seq = gen_seq + 16'd1;
    else if (r < 16) seq = gen_seq + 16'($urandom_range(2, 40));
    else if (r == 16) seq = gen_seq;
    else if (r == 17) seq = gen_seq - 16'($urandom_range(1, 32768));
    else if (r == 18) seq = gen_seq + 16'h7FFF;
    else seq = gen_seq + 16'h8000;
    if (seq - gen_seq != 0 && !(16'(seq - gen_seq) & 16'h8000)) gen_seq = seq;
    if ($urandom_range(0, 19) == 0) gen_boot = 16'($urandom);
    fr[0] = SYNC_FIRST;
    fr[1] = SYNC_SECOND;
    fr[2] = LINK_VERSION;
    fr[3] = LINK_TYPE;
    fr[4] = 8'(FRAME_BYTES);
    fr[5] = flags;
    {fr[7], fr[6]} = seq;
    {fr[11], fr[10], fr[9], fr[8]} = $urandom;
    {fr[13], fr[12]} = pick_value(pos_limit, valued);
    {fr[15], fr[14]} = pick_value(vel_limit, valued);
    r = $urandom_range(0, 19);
    fr[16] = (r < 16) ? 8'($urandom_range(0, 100)) : (r == 16) ? 8'd100 : (r == 17) ? 8'd101
             : 8'($urandom);
    fr[17] = 8'($urandom);
    fr[18] = 8'($urandom);
    fr[19] = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    {fr[21], fr[20]} = gen_boot;
    if (fault != 0 && $urandom_range(0, 2) == 0) begin
      // A sync pair buried in the frame gives the realignment something to find.
      at = $urandom_range(2, 21);
      fr[at] = SYNC_FIRST;
      if (at < 21) fr[at + 1] = SYNC_SECOND;
    end
    crc = crc16_frame(fr);
    {fr[23], fr[22]} = crc;
    if (fault == 1) begin
      at = $urandom_range(1, 4);
      fr[at] = fr[at] ^ 8'($urandom_range(1, 255));
    end else if (fault == 2) begin
      at = $urandom_range(5, 23);
      fr[at] = fr[at] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < FRAME_BYTES; i++) byte_queue.push_back(fr[i]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POSITION_LIMIT: pos_limit = int'(value);
      REG_VELOCITY_LIMIT: vel_limit = int'(value);
      REG_MEASURED_MASK: meas_mask = value[3:0];
      default: pred_mask = value[3:0];
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  function automatic int sender_idle_pct();
    return (idle_mode == 1) ? 54 : (idle_mode == 3) ? 34 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    return (idle_mode == 2) ? 54 : (idle_mode == 3) ? 34 : 0;
  endfunction

  // Driver: one byte transfer per accepted push; the predictor runs on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      rx_byte <= 8'h00;
    end else begin
      if (push && !full) begin
        predict_byte(rx_byte);
        void'(byte_queue.pop_front());
      end
      if (push && full) begin
        // Hold the offered byte until it is taken.
      end else if (byte_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        push <= 1'b1;
        rx_byte <= byte_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expected frame result.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual event %0d", $time,
                   event_code);
        end else begin
          check_field("event_code", frame_results[0].event_code, event_code);
          check_field("frame_flags", frame_results[0].frame_flags, frame_flags);
          check_field("sequence_number", frame_results[0].sequence_number, sequence_number);
          check_field("capture_time", frame_results[0].capture_time, capture_time);
          check_field("position_value", frame_results[0].position_value,
                      $unsigned(position_value));
          check_field("velocity_value", frame_results[0].velocity_value,
                      $unsigned(velocity_value));
          check_field("confidence_level", frame_results[0].confidence_level,
                      confidence_level);
          check_field("lost_count", frame_results[0].lost_count, lost_count);
          check_field("processing_time", frame_results[0].processing_time, processing_time);
          check_field("boot_identifier", frame_results[0].boot_identifier, boot_identifier);
          check_field("skipped_sequences", frame_results[0].skipped_sequences,
                      skipped_sequences);
          void'(frame_results.pop_front());
        end
      end
      if (hold_served < hold_requests) begin
        hold_cnt = HOLD_CYCLES;
        hold_served++;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      pop <= (hold_cnt == 0) && ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("framed_byte_link_receiver test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int added;
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_POSITION_LIMIT;
    cfg_data = 15'd0;
    pos_limit = 1300;
    vel_limit = 5000;
    meas_mask = 4'h1;
    pred_mask = 4'h2;
    buf_fill = 0;
    link_open = 1'b0;
    link_boot = 16'h0000;
    last_seq = 16'h0000;
    idle_mode = 0;
    hold_requests = 0;
    error_count = 0;
    gen_seq = 16'($urandom);
    gen_boot = 16'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_POSITION_LIMIT, 15'd1300);
          write_reg(REG_VELOCITY_LIMIT, 15'd5000);
          write_reg(REG_MEASURED_MASK, 15'd1);
          write_reg(REG_PREDICTED_MASK, 15'd2);
        end
        1: begin
          write_reg(REG_POSITION_LIMIT, 15'd0);
          write_reg(REG_VELOCITY_LIMIT, 15'd0);
          write_reg(REG_MEASURED_MASK, 15'hF);
          write_reg(REG_PREDICTED_MASK, 15'h0);
        end
        2: begin
          write_reg(REG_POSITION_LIMIT, 15'h7FFF);
          write_reg(REG_VELOCITY_LIMIT, 15'h7FFF);
          write_reg(REG_MEASURED_MASK, 15'h0);
          write_reg(REG_PREDICTED_MASK, 15'hF);
        end
        3: begin
          write_reg(REG_POSITION_LIMIT, 15'd100);
          write_reg(REG_VELOCITY_LIMIT, 15'h7FFF);
          write_reg(REG_MEASURED_MASK, 15'h3);
          write_reg(REG_PREDICTED_MASK, 15'h6);
        end
        default: begin
          write_reg(REG_POSITION_LIMIT, 15'($urandom_range(1, 32766)));
          write_reg(REG_VELOCITY_LIMIT, 15'($urandom_range(1, 32766)));
          write_reg(REG_MEASURED_MASK, 15'h1);
          write_reg(REG_PREDICTED_MASK, 15'h2);
        end
      endcase
      idle_mode = (ph < 4) ? ph : $urandom_range(0, 3);
      if (ph == 0) begin
        // Sync hunting: stray bytes, a lone sync byte, repeated first sync bytes.
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(SYNC_FIRST);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(SYNC_FIRST);
        queue_frame(0);
        hold_requests++;
      end
      added = 0;
      while (added < 220) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          repeat ($urandom_range(1, 6)) begin
            byte_queue.push_back(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
            added++;
          end
        end else begin
          queue_frame((r < 15) ? 0 : (r < 17) ? 1 : 2);
          added += FRAME_BYTES;
        end
      end
      while (byte_queue.size() != 0 || push || frame_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (error_count == 0 && frame_results.size() == 0) begin
      $display("framed_byte_link_receiver test passed");
    end else begin
      $display("framed_byte_link_receiver test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fblr_pkg.sv
hw/rtl/fblr_queue.sv
hw/rtl/fblr_front.sv
hw/rtl/fblr_engine.sv
hw/rtl/framed_byte_link_receiver.sv
tb/testbench.sv
